### hw/rtl/evs_pkg.sv
// Shared types, constants and register codes for the energy VAD segmenter.
// Used by the register block, the step logic and the top level.
`default_nettype none

package evs_pkg;

  localparam int unsigned WINDOW_SAMPLES_DEF = 24000;
  localparam int unsigned BLOCK_SAMPLES_DEF  = 512;

  localparam int unsigned AddrW = 4;

  // Noise floor after reset, 300.0 in Q16.8.
  localparam logic [23:0] NOISE_RESET = 24'd76800;
  // EMA weights in units of 2^-16: 0.98 and 0.02.
  localparam logic [15:0] KEEP_WEIGHT = 16'd64225;
  localparam logic [10:0] NEW_WEIGHT  = 11'd1311;

  localparam logic [3:0]  START_FACTOR_RST = 4'd4;
  localparam logic [3:0]  END_FACTOR_RST   = 4'd2;
  localparam logic [15:0] SILENCE_LIM_RST  = 16'd700;
  localparam logic [15:0] MAX_CAPTURE_RST  = 16'd2500;

  typedef enum logic [1:0] {
    REG_START_FACTOR = 2'd0,
    REG_END_FACTOR   = 2'd1,
    REG_SILENCE_LIM  = 2'd2,
    REG_MAX_CAPTURE  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_SILENCE = 2'd1,
    REASON_FULL    = 2'd2
  } end_reason_e;

  typedef struct packed {
    logic [3:0]  start_factor;
    logic [3:0]  end_factor;
    logic [15:0] silence_limit_ms;
    logic [15:0] max_capture_ms;
  } cfg_t;

  typedef struct packed {
    logic        capturing;
    logic [23:0] noise;
    logic [15:0] sample_count;
    logic        in_silence;
    logic [31:0] silence_start_ms;
    logic [31:0] capture_start_ms;
  } state_t;

  typedef struct packed {
    logic        capturing;
    logic        capture_started;
    logic        segment_done;
    end_reason_e end_reason;
    logic [15:0] segment_samples;
    logic [23:0] noise_level;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/evs_in_if.sv
// Input channel of the segmenter: one block level and its timestamp per transfer.
// Stands alone; no package dependency.
`default_nettype none

interface evs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_rms;
  logic [31:0] now_ms;

  modport source (output valid, output block_rms, output now_ms, input ready);
  modport sink   (input valid, input block_rms, input now_ms, output ready);
endinterface

`default_nettype wire

### hw/rtl/evs_out_if.sv
// Result channel of the segmenter: mode, segment events and noise floor per transfer.
// Stands alone; no package dependency.
`default_nettype none

interface evs_out_if;
  logic        valid;
  logic        ready;
  logic        capturing;
  logic        capture_started;
  logic        segment_done;
  logic [1:0]  end_reason;
  logic [15:0] segment_samples;
  logic [23:0] noise_level;

  modport source (output valid, output capturing, output capture_started,
                  output segment_done, output end_reason, output segment_samples,
                  output noise_level, input ready);
  modport sink   (input valid, input capturing, input capture_started,
                  input segment_done, input end_reason, input segment_samples,
                  input noise_level, output ready);
endinterface

`default_nettype wire

### hw/rtl/evs_cfg_regs.sv
// APB-style configuration registers of the segmenter.
// Depends on evs_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module evs_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [evs_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready,
  output      evs_pkg::cfg_t             cfg_o
);

  evs_pkg::cfg_t    cfg_q;
  evs_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = evs_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_factor     <= evs_pkg::START_FACTOR_RST;
      cfg_q.end_factor       <= evs_pkg::END_FACTOR_RST;
      cfg_q.silence_limit_ms <= evs_pkg::SILENCE_LIM_RST;
      cfg_q.max_capture_ms   <= evs_pkg::MAX_CAPTURE_RST;
    end else if (wr_en) begin
      case (idx)
        evs_pkg::REG_START_FACTOR: cfg_q.start_factor     <= pwdata[3:0];
        evs_pkg::REG_END_FACTOR:   cfg_q.end_factor       <= pwdata[3:0];
        evs_pkg::REG_SILENCE_LIM:  cfg_q.silence_limit_ms <= pwdata[15:0];
        evs_pkg::REG_MAX_CAPTURE:  cfg_q.max_capture_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      evs_pkg::REG_START_FACTOR: prdata = {28'd0, cfg_q.start_factor};
      evs_pkg::REG_END_FACTOR:   prdata = {28'd0, cfg_q.end_factor};
      evs_pkg::REG_SILENCE_LIM:  prdata = {16'd0, cfg_q.silence_limit_ms};
      evs_pkg::REG_MAX_CAPTURE:  prdata = {16'd0, cfg_q.max_capture_ms};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/evs_step.sv
// Next-state and result logic for one audio block of the segmenter.
// Depends on evs_pkg for cfg_t, state_t, result_t and the EMA weights.
`default_nettype none

module evs_step #(
  parameter int unsigned WINDOW_SAMPLES = evs_pkg::WINDOW_SAMPLES_DEF,
  parameter int unsigned BLOCK_SAMPLES  = evs_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire logic [15:0]     block_rms_i,
  input  wire logic [31:0]     now_ms_i,
  input  wire evs_pkg::cfg_t   cfg_i,
  input  wire evs_pkg::state_t state_i,
  output      evs_pkg::state_t state_o,
  output      evs_pkg::result_t result_o
);

  localparam logic [15:0] WinSamples = 16'(WINDOW_SAMPLES);
  localparam logic [15:0] BlkSamples = 16'(BLOCK_SAMPLES);

  logic [23:0] level;
  logic [40:0] acc;
  logic [23:0] noise_ema;
  logic [27:0] start_thr;
  logic [27:0] end_thr;
  logic        trigger;
  logic        quiet;
  logic [15:0] room;
  logic [15:0] add;
  logic [15:0] count_sum;
  logic        sil_now;
  logic [31:0] sil_start;
  logic [31:0] sil_elapsed;
  logic [31:0] cap_elapsed;
  logic        end_sil;
  logic        end_max;

  assign level = {block_rms_i, 8'd0};

  // Constant-weight EMA; the weights sum to 2^16 so the result fits in Q16.8.
  assign acc       = 41'(state_i.noise) * 41'(evs_pkg::KEEP_WEIGHT)
                   + 41'(level) * 41'(evs_pkg::NEW_WEIGHT);
  assign noise_ema = acc[39:16];

  // The start test uses the floor just updated; the silence test the held floor.
  assign start_thr = 28'(noise_ema) * 28'(cfg_i.start_factor);
  assign end_thr   = 28'(state_i.noise) * 28'(cfg_i.end_factor);
  assign trigger   = 28'(level) > start_thr;
  assign quiet     = 28'(level) < end_thr;

  assign room      = (state_i.sample_count < WinSamples) ?
                     (WinSamples - state_i.sample_count) : 16'd0;
  assign add       = (BlkSamples < room) ? BlkSamples : room;
  assign count_sum = state_i.sample_count + add;

  assign sil_now     = quiet;
  assign sil_start   = (quiet && !state_i.in_silence) ? now_ms_i : state_i.silence_start_ms;
  assign sil_elapsed = now_ms_i - sil_start;
  assign cap_elapsed = now_ms_i - state_i.capture_start_ms;
  assign end_sil     = sil_now && (sil_elapsed >= {16'd0, cfg_i.silence_limit_ms});
  assign end_max     = (count_sum >= WinSamples) ||
                       (cap_elapsed >= {16'd0, cfg_i.max_capture_ms});

  always_comb begin
    state_o                  = state_i;
    result_o.capture_started = 1'b0;
    result_o.segment_done    = 1'b0;
    result_o.end_reason      = evs_pkg::REASON_NONE;
    result_o.segment_samples = state_i.sample_count;

    if (!state_i.capturing) begin
      state_o.noise = noise_ema;
      if (trigger) begin
        state_o.sample_count     = 16'd0;
        state_o.in_silence       = 1'b0;
        state_o.capture_start_ms = now_ms_i;
        state_o.capturing        = 1'b1;
        result_o.capture_started = 1'b1;
      end
      result_o.segment_samples = state_o.sample_count;
    end else begin
      state_o.sample_count     = count_sum;
      state_o.in_silence       = sil_now;
      state_o.silence_start_ms = sil_start;
      result_o.segment_samples = count_sum;
      if (end_sil || end_max) begin
        result_o.segment_done = 1'b1;
        result_o.end_reason   = end_sil ? evs_pkg::REASON_SILENCE : evs_pkg::REASON_FULL;
        state_o.sample_count  = 16'd0;
        state_o.capturing     = 1'b0;
      end
    end

    result_o.capturing   = state_o.capturing;
    result_o.noise_level = state_o.noise;
  end

endmodule

`default_nettype wire

### hw/rtl/energy_vad_segmenter_core.sv
// Top level of the energy VAD segmenter: input register, step logic, result register.
// Depends on evs_pkg, evs_in_if, evs_out_if, evs_cfg_regs and evs_step.
`default_nettype none

// Energy-based voice activity segmenter with an adaptive noise floor. Each
// input transfer carries one audio block's RMS level and its millisecond
// timestamp and produces exactly one result transfer. One block is taken in
// every clock cycle while the result output is not stalled; a block is held in
// the input register until the result register is free, and its result is then
// loaded into the result register. The segmenter state is updated as the
// result register loads, so the next block already sees it. A stalled result
// only holds the input register; the configuration registers should be
// written while no block is in flight.
module energy_vad_segmenter_core #(
  parameter int unsigned WINDOW_SAMPLES = evs_pkg::WINDOW_SAMPLES_DEF,
  parameter int unsigned BLOCK_SAMPLES  = evs_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  evs_in_if.sink                         in_i,
  evs_out_if.source                      out_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [evs_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);

  evs_pkg::cfg_t    cfg;
  evs_pkg::state_t  state_q, state_d;
  evs_pkg::result_t res_d, res_q;

  logic        in_valid_q;
  logic [15:0] rms_q;
  logic [31:0] now_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_take;

  evs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  evs_step #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .BLOCK_SAMPLES  (BLOCK_SAMPLES)
  ) u_step (
    .block_rms_i (rms_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rms_q <= in_i.block_rms;
      now_q <= in_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.capturing        <= 1'b0;
      state_q.noise            <= evs_pkg::NOISE_RESET;
      state_q.sample_count     <= 16'd0;
      state_q.in_silence       <= 1'b0;
      state_q.silence_start_ms <= 32'd0;
      state_q.capture_start_ms <= 32'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.capturing       = res_q.capturing;
  assign out_o.capture_started = res_q.capture_started;
  assign out_o.segment_done    = res_q.segment_done;
  assign out_o.end_reason      = res_q.end_reason;
  assign out_o.segment_samples = res_q.segment_samples;
  assign out_o.noise_level     = res_q.noise_level;

  // A block that starts a capture leaves the segmenter capturing.
  a_start_capturing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.capture_started |-> res_q.capturing)
    else $error("capture start reported without capturing mode");

  // A finished segment always carries a reason and returns to listening.
  a_done_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.segment_done |->
      !res_q.capturing && (res_q.end_reason != evs_pkg::REASON_NONE))
    else $error("segment end without reason or still capturing");

  // The sample count is cleared whenever the segmenter is listening.
  a_listen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.capturing |-> state_q.sample_count == 16'd0)
    else $error("sample count not cleared while listening");

  // The noise floor only moves while listening.
  a_noise_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.capturing |=> $stable(state_q.noise))
    else $error("noise floor changed during capture");

endmodule

`default_nettype wire
